// File: design/thq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain height query package
// Shared constants, codes and the control type of the height query pipeline.
// ----------------------------------------------------------------------------
package thq_pkg;

  localparam int TILE_WIDTH_DEF = 132;
  localparam int TILE_CELLS_DEF = 128;

  localparam int FX_FRAC = 12;
  localparam int FX_ONE = 4096;
  localparam int FX_HALF = 2048;
  localparam int WORLD_SHIFT = 32 * FX_ONE;

  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_OFFSET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_SCALE = 1'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic valid;
    logic outside;
  } ctl_t;

endpackage
`default_nettype wire

// File: design/thq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module thq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/thq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell locator
// Maps a query point to its grid cell and the four corner addresses, and
// carries sample writes along so they reach the tile in item order.
// ----------------------------------------------------------------------------
module thq_cell #(
  parameter int TILE_WIDTH = thq_pkg::TILE_WIDTH_DEF,
  parameter int TILE_CELLS = thq_pkg::TILE_CELLS_DEF,
  localparam int DEPTH = TILE_WIDTH * TILE_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic               op,
  input  wire logic [14:0]        sample_index,
  input  wire logic [7:0]         sample_height,
  input  wire logic signed [31:0] query_x,
  input  wire logic signed [31:0] query_z,
  output      thq_pkg::ctl_t      ctl,
  output      logic [11:0]        frac_x,
  output      logic [11:0]        frac_z,
  output      logic [AW-1:0]      addr [4],
  output      logic [3:0]         beyond,
  output      logic               wr_en,
  output      logic [AW-1:0]      wr_addr,
  output      logic [7:0]         wr_data
);

  import thq_pkg::*;

  localparam int CW = $clog2(TILE_CELLS);
  localparam int IW = $clog2((TILE_CELLS + 3) * TILE_WIDTH + TILE_CELLS + 4) + 1;

  logic signed [32:0] sum_x;
  logic signed [32:0] sum_z;
  logic               out_x;
  logic               out_z;

  ctl_t        ctl1;
  logic        wr1;
  logic [14:0] widx1;
  logic [7:0]  wdat1;
  logic [CW-1:0] col1;
  logic [CW-1:0] row1;
  logic [11:0] fx1;
  logic [11:0] fz1;

  logic [IW-1:0] base;
  logic [IW-1:0] idx [4];

  always_comb begin
    sum_x = {query_x[31], query_x} + 33'(WORLD_SHIFT);
    sum_z = {query_z[31], query_z} + 33'(WORLD_SHIFT);
    out_x = sum_x[32] || (sum_x[32:FX_FRAC] >= 21'(TILE_CELLS));
    out_z = sum_z[32] || (sum_z[32:FX_FRAC] >= 21'(TILE_CELLS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      wr1 <= 1'b0;
    end else if (en) begin
      ctl1.valid <= in_valid && (op == OP_QUERY);
      wr1 <= in_valid && (op == OP_WRITE);
    end
    if (en) begin
      ctl1.outside <= out_x || out_z;
      widx1 <= sample_index;
      wdat1 <= sample_height;
      col1 <= sum_x[FX_FRAC +: CW];
      row1 <= sum_z[FX_FRAC +: CW];
      fx1 <= sum_x[FX_FRAC-1:0];
      fz1 <= sum_z[FX_FRAC-1:0];
    end
  end

  always_comb begin
    base = IW'(2 * TILE_WIDTH + 2) + IW'(row1) * IW'(TILE_WIDTH) + IW'(col1);
    idx[0] = base;
    idx[1] = base + IW'(TILE_WIDTH);
    idx[2] = base + IW'(1);
    idx[3] = base + IW'(TILE_WIDTH + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
      wr_en <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl1.valid;
      wr_en <= wr1 && (int'(widx1) < DEPTH);
    end
    if (en) begin
      ctl.outside <= ctl1.outside;
      frac_x <= fx1;
      frac_z <= fz1;
      wr_addr <= AW'(widx1);
      wr_data <= wdat1;
      for (int i = 0; i < 4; i++) begin
        addr[i] <= idx[i][AW-1:0];
        beyond[i] <= int'(idx[i]) >= DEPTH;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/thq_interp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle interpolator
// Scales the corner samples, picks the triangle and evaluates its plane at
// the query point, ending in the output register.
// ----------------------------------------------------------------------------
module thq_interp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire thq_pkg::ctl_t ctl,
  input  wire logic [11:0]   frac_x,
  input  wire logic [11:0]   frac_z,
  input  wire logic [7:0]    raw [4],
  input  wire logic [3:0]    beyond,
  input  wire logic [7:0]    height_offset,
  input  wire logic [15:0]   height_scale,
  output      logic          res_valid,
  output      logic [31:0]   height_y,
  output      logic          outside
);

  import thq_pkg::*;

  logic signed [8:0]  sd [4];
  logic [12:0]        fsum;

  ctl_t               ctl4;
  logic signed [25:0] h4 [4];
  logic               abc4;
  logic [11:0]        fx4;
  logic [11:0]        fz4;

  ctl_t               ctl5;
  logic signed [25:0] hb5;
  logic signed [26:0] n1_5;
  logic signed [26:0] n2_5;
  logic signed [12:0] f1_5;
  logic signed [12:0] f2_5;

  ctl_t               ctl6;
  logic signed [25:0] hb6;
  logic signed [39:0] p1_6;
  logic signed [39:0] p2_6;

  logic signed [39:0] r1;
  logic signed [39:0] r2;
  logic signed [39:0] yw;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sd[i] = $signed({1'b0, (beyond[i] ? 8'd0 : raw[i])}) - $signed({1'b0, height_offset});
    end
    fsum = {1'b0, frac_x} + {1'b0, frac_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.valid <= 1'b0;
      ctl5.valid <= 1'b0;
      ctl6.valid <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      ctl4.valid <= ctl.valid;
      ctl5.valid <= ctl4.valid;
      ctl6.valid <= ctl5.valid;
      res_valid <= ctl6.valid;
    end
    if (en) begin
      ctl4.outside <= ctl.outside;
      for (int i = 0; i < 4; i++) begin
        h4[i] <= 26'(sd[i]) * 26'($signed({1'b0, height_scale}));
      end
      abc4 <= (frac_x != 12'd0) && (frac_z != 12'd0) && (fsum < 13'(FX_ONE));
      fx4 <= frac_x;
      fz4 <= frac_z;

      ctl5.outside <= ctl4.outside;
      f2_5 <= $signed({1'b0, fz4});
      if (abc4) begin
        hb5 <= h4[0];
        n1_5 <= 27'(h4[0]) - 27'(h4[2]);
        n2_5 <= 27'(h4[0]) - 27'(h4[1]);
        f1_5 <= $signed({1'b0, fx4});
      end else begin
        hb5 <= h4[2];
        n1_5 <= 27'(h4[1]) - 27'(h4[3]);
        n2_5 <= 27'(h4[2]) - 27'(h4[3]);
        f1_5 <= $signed({1'b0, fx4}) - 13'sd4096;
      end

      ctl6.outside <= ctl5.outside;
      hb6 <= hb5;
      p1_6 <= 40'(n1_5) * 40'(f1_5);
      p2_6 <= 40'(n2_5) * 40'(f2_5);

      outside <= ctl6.outside;
      height_y <= ctl6.outside ? 32'd0 : yw[31:0];
    end
  end

  always_comb begin
    r1 = (p1_6 + 40'sd2048) >>> FX_FRAC;
    r2 = (p2_6 + 40'sd2048) >>> FX_FRAC;
    yw = 40'(hb6) - r1 - r2;
  end

endmodule
`default_nettype wire

// File: design/terrain_height_query.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain height query
// Bordered heightmap tile with triangle plane interpolation of height.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the output is not stalled and
// returns one result per query; write items give no result. The pipeline
// runs cell location, corner addressing, four parallel tile reads, scaling,
// triangle selection, the two plane products and the final sum. The tile
// is held in four copies so that all corners read together. Writes land
// in the tile at the read stage, so every query sees exactly the writes
// accepted before it. A stall at the output holds the whole pipeline.
module terrain_height_query #(
  parameter int TILE_WIDTH = thq_pkg::TILE_WIDTH_DEF,
  parameter int TILE_CELLS = thq_pkg::TILE_CELLS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // sample_index, sample_height, query_x, query_z, zero pad
  input  wire logic [thq_pkg::IN_DATA_W-1:0]    s_tdata,
  // op
  input  wire logic                             s_tuser,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // height_y
  output      logic [thq_pkg::OUT_DATA_W-1:0]   m_tdata,
  // outside
  output      logic                             m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [thq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [thq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import thq_pkg::*;

  localparam int DEPTH = TILE_WIDTH * TILE_WIDTH;
  localparam int AW = $clog2(DEPTH);

  logic          en;
  logic [7:0]    height_offset;
  logic [15:0]   height_scale;

  ctl_t          ctl2;
  logic [11:0]   fx2;
  logic [11:0]   fz2;
  logic [AW-1:0] addr2 [4];
  logic [3:0]    beyond2;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  ctl_t          ctl3;
  logic [11:0]   fx3;
  logic [11:0]   fz3;
  logic [3:0]    beyond3;
  logic [7:0]    raw3 [4];

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_offset <= 8'd128;
      height_scale <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEIGHT_OFFSET: height_offset <= cfg_wdata[7:0];
        REG_HEIGHT_SCALE:  height_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  thq_cell #(
    .TILE_WIDTH(TILE_WIDTH),
    .TILE_CELLS(TILE_CELLS)
  ) u_cell (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s_tvalid),
    .op(s_tuser),
    .sample_index(s_tdata[14:0]),
    .sample_height(s_tdata[22:15]),
    .query_x(s_tdata[54:23]),
    .query_z(s_tdata[86:55]),
    .ctl(ctl2),
    .frac_x(fx2),
    .frac_z(fz2),
    .addr(addr2),
    .beyond(beyond2),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  for (genvar g = 0; g < 4; g++) begin : g_tile
    thq_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk(clk),
      .we(wr_en && en),
      .waddr(wr_addr),
      .wdata(wr_data),
      .re(en),
      .raddr(addr2[g]),
      .rdata(raw3[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else if (en) begin
      ctl3.valid <= ctl2.valid;
    end
    if (en) begin
      ctl3.outside <= ctl2.outside;
      fx3 <= fx2;
      fz3 <= fz2;
      beyond3 <= beyond2;
    end
  end

  thq_interp u_interp (
    .clk(clk),
    .rst(rst),
    .en(en),
    .ctl(ctl3),
    .frac_x(fx3),
    .frac_z(fz3),
    .raw(raw3),
    .beyond(beyond3),
    .height_offset(height_offset),
    .height_scale(height_scale),
    .res_valid(m_tvalid),
    .height_y(m_tdata),
    .outside(m_tuser)
  );

endmodule
`default_nettype wire

// File: design/thq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain height query checker
// Port-level checks of the output stage, bound to the top level.
// ----------------------------------------------------------------------------
module thq_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [thq_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                           m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Result changed while stalled.");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("Outside result carries a nonzero height.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Result present right after reset.");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("Input ready does not follow the output stage.");

endmodule

bind terrain_height_query thq_checker u_thq_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terrain height query testbench
// Loads the corner samples of a window of cells and of the two tile corners,
// then runs directed and random write and query items under several height
// scalings, with random sender gaps and receiver stalls. Query results are
// checked against a local plane predictor or against given expected values.
// ----------------------------------------------------------------------------
module tb;
  import thq_pkg::*;

  localparam int TW = TILE_WIDTH_DEF;
  localparam int TC = TILE_CELLS_DEF;
  localparam int DEPTH = TW * TW;
  localparam int SKIP = 2 * TW + 2;
  localparam longint LINE_TOP = 256 * FX_ONE;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int WIN_LO = 28;
  localparam int WIN_HI = 35;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  typedef struct packed {
    logic [31:0] y;
    logic        outside;
  } height_res_t;

  typedef struct {
    logic        op;
    int          idx;
    int          h;
    int          x;
    int          z;
    bit          typed;
    height_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = OP_WRITE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_HEIGHT_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [7:0] tile_copy [DEPTH];
  longint offset_copy = 128;
  longint scale_copy = 4096;
  height_res_t heights_due [$];
  height_res_t typed_due [$];
  bit typed_flags [$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  always #2 clk = ~clk;

  terrain_height_query u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + 2048) >>> 12;
  endfunction

  function automatic longint corner(int idx);
    longint raw;
    raw = (idx >= 0 && idx < DEPTH) ? longint'(tile_copy[idx]) : 0;
    return (raw - offset_copy) * scale_copy;
  endfunction

  function automatic longint side(vec_t p, vec_t q, vec_t r);
    return fx_mul(p.x - r.x, q.z - r.z) - fx_mul(q.x - r.x, p.z - r.z);
  endfunction

  function automatic longint plane_y(vec_t o, vec_t p, vec_t q, longint px, longint pz);
    longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, pd, top;
    e1x = p.x - o.x; e1y = p.y - o.y; e1z = p.z - o.z;
    e2x = q.x - o.x; e2y = q.y - o.y; e2z = q.z - o.z;
    nx = (e1y * e2z - e1z * e2y + 2048) >>> 12;
    ny = (e1z * e2x - e1x * e2z + 2048) >>> 12;
    nz = (e1x * e2y - e1y * e2x + 2048) >>> 12;
    pd = -(fx_mul(nx, o.x) + fx_mul(ny, o.y) + fx_mul(nz, o.z));
    top = fx_mul(nx, px) + pd + fx_mul(ny, LINE_TOP) + fx_mul(nz, pz);
    return LINE_TOP - top;
  endfunction

  function automatic height_res_t terrain_height(logic [31:0] qx, logic [31:0] qz);
    height_res_t r;
    longint x, z, col, row, y;
    int base;
    vec_t pt, a, b, c, d;
    bit s1, s2, s3;
    x = longint'($signed(qx));
    z = longint'($signed(qz));
    col = (x + WORLD_SHIFT) >>> 12;
    row = (z + WORLD_SHIFT) >>> 12;
    if (col < 0 || row < 0 || col >= TC || row >= TC) begin
      r.y = '0;
      r.outside = 1'b1;
      return r;
    end
    base = SKIP + int'(row) * TW + int'(col);
    a.x = col * FX_ONE - WORLD_SHIFT; a.z = row * FX_ONE - WORLD_SHIFT;
    b.x = a.x; b.z = a.z + FX_ONE;
    c.x = a.x + FX_ONE; c.z = a.z;
    d.x = a.x + FX_ONE; d.z = a.z + FX_ONE;
    a.y = corner(base);
    b.y = corner(base + TW);
    c.y = corner(base + 1);
    d.y = corner(base + TW + 1);
    pt.x = x; pt.y = LINE_TOP; pt.z = z;
    s1 = side(pt, a, b) < 0;
    s2 = side(pt, b, c) < 0;
    s3 = side(pt, c, a) < 0;
    if (s1 == s2 && s2 == s3) y = plane_y(a, b, c, x, z);
    else y = plane_y(c, b, d, x, z);
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    r.y = y[31:0];
    r.outside = 1'b0;
    return r;
  endfunction

  // Accepted items update the tile copy and queue predictions; results are
  // checked in order of arrival.
  always @(posedge clk) begin
    height_res_t got, want;
    bit typed;
    int idx;
    if (!rst && s_tvalid && s_tready) begin
      if (s_tuser == OP_WRITE) begin
        idx = int'(s_tdata[14:0]);
        if (idx < DEPTH) tile_copy[idx] = s_tdata[22:15];
      end else begin
        heights_due.push_back(terrain_height(s_tdata[54:23], s_tdata[86:55]));
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      got.y = m_tdata;
      got.outside = m_tuser;
      if (heights_due.size() == 0) begin
        $error("result with no query waiting: height_y %0d outside %0d",
               $signed(got.y), got.outside);
        errors++;
      end else begin
        want = heights_due.pop_front();
        typed = typed_flags.pop_front();
        if (typed) want = typed_due.pop_front();
        if (got.y !== want.y) begin
          $error("height_y expected %0d actual %0d", $signed(want.y), $signed(got.y));
          errors++;
        end
        if (got.outside !== want.outside) begin
          $error("outside expected %0d actual %0d", want.outside, got.outside);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL terrain_height_query");
      $finish;
    end
  end

  // The receiver switches between always ready, light and heavy stalls.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send_item(logic op, int idx, int h, int x, int z);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {1'b0, z[31:0], x[31:0], h[7:0], idx[14:0]};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_query(int x, int z);
    typed_flags.push_back(1'b0);
    send_item(OP_QUERY, 0, 0, x, z);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (heights_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] which, int value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (which == REG_HEIGHT_OFFSET) offset_copy = value & 255;
    else scale_copy = value & 65535;
  endtask

  // Queries inside the tile stay in the loaded window of cells.
  function automatic int cell_coord();
    case ($urandom_range(0, 5))
      0: return -131072 + int'($urandom_range(WIN_LO, WIN_HI)) * FX_ONE;
      1: return -131072 + int'($urandom_range(WIN_LO + 1, WIN_HI + 1)) * FX_ONE - 1;
      default: return int'($urandom_range(WIN_LO * FX_ONE, (WIN_HI + 1) * FX_ONE - 1))
                      - 131072;
    endcase
  endfunction

  stim_row_t rows [$];

  function automatic stim_row_t row_of(logic op, int idx, int h, int x, int z,
                                       bit typed, logic [31:0] y, logic outside);
    stim_row_t r;
    r.op = op; r.idx = idx; r.h = h; r.x = x; r.z = z;
    r.typed = typed; r.res.y = y; r.res.outside = outside;
    return r;
  endfunction

  initial begin
    int phase, n, kind, x, z;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = WIN_LO; r <= WIN_HI + 1; r++) begin
      for (int c = WIN_LO; c <= WIN_HI + 1; c++) begin
        send_item(OP_WRITE, SKIP + r * TW + c, $urandom_range(0, 255), 0, 0);
      end
    end
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        send_item(OP_WRITE, SKIP + r * TW + c, $urandom_range(0, 255), 0, 0);
        send_item(OP_WRITE, SKIP + (TC - 1 + r) * TW + TC - 1 + c,
                  $urandom_range(0, 255), 0, 0);
      end
    end

    // Out of range cells report outside with zero height.
    rows.push_back(row_of(OP_QUERY, 0, 0, 32'h8000_0000, 0, 1, 0, 1));
    rows.push_back(row_of(OP_QUERY, 0, 0, 32'h7fff_ffff, 0, 1, 0, 1));
    rows.push_back(row_of(OP_QUERY, 0, 0, 0, 32'h8000_0000, 1, 0, 1));
    rows.push_back(row_of(OP_QUERY, 0, 0, 0, 32'h7fff_ffff, 1, 0, 1));
    rows.push_back(row_of(OP_QUERY, 0, 0, -131073, 0, 1, 0, 1));
    rows.push_back(row_of(OP_QUERY, 0, 0, 393216, 0, 1, 0, 1));
    rows.push_back(row_of(OP_QUERY, 0, 0, 0, -131073, 1, 0, 1));
    rows.push_back(row_of(OP_QUERY, 0, 0, 0, 393216, 1, 0, 1));
    // Writes past the tile are dropped; the last and first entries are kept.
    rows.push_back(row_of(OP_WRITE, 32767, 255, 0, 0, 0, 0, 0));
    rows.push_back(row_of(OP_WRITE, DEPTH, 0, 0, 0, 0, 0, 0));
    rows.push_back(row_of(OP_WRITE, DEPTH - 1, 255, 0, 0, 0, 0, 0));
    rows.push_back(row_of(OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, -131072, -131072, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 393215, 393215, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 2048, 1024, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 1024, 2048, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 2048, 2048, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 100, 4000, 0, 0, 0));
    // A query right after a write to its own corner sees the new height.
    rows.push_back(row_of(OP_WRITE, SKIP + 32 * TW + 32, 255, 0, 0, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 100, 100, 0, 0, 0));
    rows.push_back(row_of(OP_WRITE, SKIP + 33 * TW + 33, 0, 0, 0, 0, 0, 0));
    rows.push_back(row_of(OP_QUERY, 0, 0, 4000, 4000, 0, 0, 0));

    foreach (rows[i]) begin
      if (rows[i].op == OP_QUERY) begin
        typed_flags.push_back(rows[i].typed);
        if (rows[i].typed) typed_due.push_back(rows[i].res);
      end
      send_item(rows[i].op, rows[i].idx, rows[i].h, rows[i].x, rows[i].z);
    end

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(REG_HEIGHT_OFFSET, 0); write_reg(REG_HEIGHT_SCALE, 65535); end
        1: begin write_reg(REG_HEIGHT_OFFSET, 255); write_reg(REG_HEIGHT_SCALE, 0); end
        2: begin write_reg(REG_HEIGHT_OFFSET, 255); write_reg(REG_HEIGHT_SCALE, 65535); end
        3: begin write_reg(REG_HEIGHT_OFFSET, 128); write_reg(REG_HEIGHT_SCALE, 4096); end
        default: begin
          write_reg(REG_HEIGHT_OFFSET, $urandom_range(0, 255));
          write_reg(REG_HEIGHT_SCALE, $urandom_range(0, 65535));
        end
      endcase
      for (n = 0; n < 200; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          send_query(cell_coord(), cell_coord());
        end else if (kind < 68) begin
          x = $urandom();
          if (x >= -131072 && x < 393216) x = cell_coord();
          z = ($urandom_range(0, 1) == 0) ? $urandom() : cell_coord();
          if (z >= -131072 && z < 393216) z = cell_coord();
          if ($urandom_range(0, 1) == 0) begin
            kind = x; x = z; z = kind;
          end
          send_query(x, z);
        end else if (kind < 95) begin
          send_item(OP_WRITE, $urandom_range(0, DEPTH - 1), $urandom_range(0, 255), 0, 0);
        end else begin
          send_item(OP_WRITE, $urandom_range(DEPTH, 32767), $urandom_range(0, 255),
                    $urandom(), $urandom());
        end
      end
    end

    wait_idle();
    if (errors == 0) $display("PASS terrain_height_query");
    else $display("FAIL terrain_height_query");
    $finish;
  end

endmodule
